>>> hdl/mq_pkg.sv
// Package: widths, stage counts and pivot codes for the matrix-to-quaternion core.
`default_nettype none
package mq_pkg;

   localparam int FRAC_BITS = 16;
   localparam int IN_W      = 18;
   localparam int OUT_MAX   = (1 << (IN_W - 1)) - 1;

   // radicand, signed
   localparam int RAD_W = (IN_W + 2 > FRAC_BITS + 2) ? IN_W + 2 : FRAC_BITS + 2;

   // square root: radicand << (FRAC_BITS-2), padded to an even width
   localparam int SQ_RAW_W  = RAD_W - 1 + FRAC_BITS - 2;
   localparam int SQ_IN_W   = SQ_RAW_W + (SQ_RAW_W % 2);
   localparam int SQ_ITERS  = SQ_IN_W / 2;
   localparam int P_W       = SQ_ITERS;
   localparam int SQ_PER    = 2;
   localparam int SQ_STAGES = (SQ_ITERS + SQ_PER - 1) / SQ_PER;

   // pair sums / differences and the scaled divide
   localparam int D_W       = IN_W + 1;
   localparam int DEN_W     = P_W + 2;
   localparam int NUM_W     = D_W + FRAC_BITS + 1;
   localparam int Q_W       = IN_W;
   localparam int REM_W     = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;
   localparam int DV_PER    = 2;
   localparam int DV_STAGES = (Q_W + DV_PER - 1) / DV_PER;
   localparam int DIV_LAT   = 1 + DV_STAGES;

   localparam int SIDE_LAT  = SQ_STAGES + DIV_LAT;

   typedef enum logic [1:0] {
      KIND_TRACE = 2'd0,
      KIND_X     = 2'd1,
      KIND_Y     = 2'd2,
      KIND_Z     = 2'd3
   } kind_type;

endpackage
`default_nettype wire

>>> hdl/mq_if.sv
// Interfaces: request (matrix) and response (quaternion) channels.
`default_nettype none
interface mq_req_if;
   logic               valid;
   logic               ready;
   logic signed [17:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
   modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                   input ready);
   modport sink   (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                   output ready);
endinterface

interface mq_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [17:0] qx, qy, qz, qw;
   logic        [1:0]  pivot_kind;
   logic               bad_input;
   modport source (output valid, qx, qy, qz, qw, pivot_kind, bad_input, input ready);
   modport sink   (input valid, qx, qy, qz, qw, pivot_kind, bad_input, output ready);
endinterface
`default_nettype wire

>>> hdl/matrix_to_quaternion_core.sv
// Top level: rotation matrix to quaternion, fully pipelined.
// Throughput: one request per cycle; the whole pipe holds while the response waits.
// The depth is set by the square root (two root bits per stage) followed by the
// three parallel dividers (two quotient bits per stage).
// Reset (synchronous, active high) clears only the valid bits; no clearing pass.
`default_nettype none
module matrix_to_quaternion_core (
   input  wire logic clock,
   input  wire logic reset,
   mq_req_if.sink    req,
   mq_rsp_if.source  rsp
);
   import mq_pkg::*;

   typedef struct packed {
      logic signed [D_W-1:0] d0;
      logic signed [D_W-1:0] d1;
      logic signed [D_W-1:0] d2;
   } pair_type;

   typedef struct packed {
      kind_type kind;
      logic     bad;
   } side_type;

   // global advance: the output register is free or being emptied
   logic en;
   assign en        = !rsp.valid || rsp.ready;
   assign req.ready = en;

   // ---------------- decode stage ----------------
   logic signed [RAD_W-1:0] a00, a11, a22, trace, rad;
   logic [SQ_IN_W-1:0]      rv_c;
   side_type                side_c;
   pair_type                pair_c;

   always_comb begin
      logic signed [D_W-1:0] s01, s20, s12, m12, m20, m01;
      a00   = RAD_W'(req.r00);
      a11   = RAD_W'(req.r11);
      a22   = RAD_W'(req.r22);
      trace = a00 + a11 + a22;
      s01   = D_W'(req.r01) + D_W'(req.r10);
      s20   = D_W'(req.r20) + D_W'(req.r02);
      s12   = D_W'(req.r12) + D_W'(req.r21);
      m12   = D_W'(req.r12) - D_W'(req.r21);
      m20   = D_W'(req.r20) - D_W'(req.r02);
      m01   = D_W'(req.r01) - D_W'(req.r10);
      // strict compares: ties go to the later candidate
      if (trace > 0) begin
         side_c.kind = KIND_TRACE;
         rad         = trace + (RAD_W'(1) <<< FRAC_BITS);
         pair_c      = '{d0: m12, d1: m20, d2: m01};
      end else if (req.r00 > req.r11 && req.r00 > req.r22) begin
         side_c.kind = KIND_X;
         rad         = a00 - a11 - a22 + (RAD_W'(1) <<< FRAC_BITS);
         pair_c      = '{d0: s01, d1: s20, d2: m12};
      end else if (req.r11 > req.r22) begin
         side_c.kind = KIND_Y;
         rad         = a11 - a00 - a22 + (RAD_W'(1) <<< FRAC_BITS);
         pair_c      = '{d0: s01, d1: s12, d2: m20};
      end else begin
         side_c.kind = KIND_Z;
         rad         = a22 - a00 - a11 + (RAD_W'(1) <<< FRAC_BITS);
         pair_c      = '{d0: s20, d1: s12, d2: m01};
      end
      side_c.bad = (rad <= 0);
      rv_c       = side_c.bad ? '0 : (SQ_IN_W'(rad[RAD_W-2:0]) << (FRAC_BITS - 2));
   end

   logic               s0_vld_ff;
   logic [SQ_IN_W-1:0] s0_rv_ff;
   side_type           s0_side_ff;
   pair_type           s0_pair_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else if (en) begin
         s0_vld_ff <= req.valid;
      end
      if (en) begin
         s0_rv_ff   <= rv_c;
         s0_side_ff <= side_c;
         s0_pair_ff <= pair_c;
      end
   end

   // ---------------- square root ----------------
   logic [P_W-1:0] p_root;

   mq_isqrt u_isqrt (
      .clock (clock),
      .en    (en),
      .rad_v (s0_rv_ff),
      .p_out (p_root)
   );

   // pair terms wait for the root
   pair_type pair_ff [SQ_STAGES];
   always_ff @(posedge clock) begin
      if (en) begin
         pair_ff[0] <= s0_pair_ff;
         for (int s = 1; s < SQ_STAGES; s++) pair_ff[s] <= pair_ff[s-1];
      end
   end

   // ---------------- dividers ----------------
   logic [Q_W-1:0] q0, q1, q2;
   logic           n0, n1, n2, o0, o1, o2;

   mq_div u_div0 (.clock(clock), .en(en), .d(pair_ff[SQ_STAGES-1].d0), .p(p_root),
                  .q_out(q0), .neg_out(n0), .ovf_out(o0));
   mq_div u_div1 (.clock(clock), .en(en), .d(pair_ff[SQ_STAGES-1].d1), .p(p_root),
                  .q_out(q1), .neg_out(n1), .ovf_out(o1));
   mq_div u_div2 (.clock(clock), .en(en), .d(pair_ff[SQ_STAGES-1].d2), .p(p_root),
                  .q_out(q2), .neg_out(n2), .ovf_out(o2));

   // pivot waits for the dividers
   logic [P_W-1:0] piv_ff [DIV_LAT];
   always_ff @(posedge clock) begin
      if (en) begin
         piv_ff[0] <= p_root;
         for (int s = 1; s < DIV_LAT; s++) piv_ff[s] <= piv_ff[s-1];
      end
   end

   // branch, flag and valid run alongside the whole datapath
   logic     vld_ff  [SIDE_LAT];
   side_type side_ff [SIDE_LAT];
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SIDE_LAT; s++) vld_ff[s] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= s0_vld_ff;
         for (int s = 1; s < SIDE_LAT; s++) vld_ff[s] <= vld_ff[s-1];
      end
      if (en) begin
         side_ff[0] <= s0_side_ff;
         for (int s = 1; s < SIDE_LAT; s++) side_ff[s] <= side_ff[s-1];
      end
   end

   // ---------------- saturate and place ----------------
   function automatic logic signed [IN_W-1:0] sat_q(input logic [Q_W-1:0] q,
                                                    input logic neg, input logic ovf);
      logic signed [IN_W-1:0] res;
      if (neg) begin
         if (ovf || q > Q_W'(OUT_MAX + 1)) res = IN_W'(-OUT_MAX - 1);
         else                               res = IN_W'(-q);
      end else begin
         if (ovf || q > Q_W'(OUT_MAX)) res = IN_W'(OUT_MAX);
         else                          res = IN_W'(q);
      end
      return res;
   endfunction

   logic signed [IN_W-1:0] c0, c1, c2, pv;
   logic signed [IN_W-1:0] qx_in, qy_in, qz_in, qw_in;
   logic                   bad_in;
   side_type               side_end;

   assign side_end = side_ff[SIDE_LAT-1];

   always_comb begin
      c0     = sat_q(q0, n0, o0);
      c1     = sat_q(q1, n1, o1);
      c2     = sat_q(q2, n2, o2);
      pv     = ((P_W + 1)'(piv_ff[DIV_LAT-1]) > (P_W + 1)'(OUT_MAX)) ?
               IN_W'(OUT_MAX) : IN_W'(piv_ff[DIV_LAT-1]);
      bad_in = side_end.bad || (piv_ff[DIV_LAT-1] == '0);
      case (side_end.kind)
         KIND_TRACE: begin
            qx_in = c0; qy_in = c1; qz_in = c2; qw_in = pv;
         end
         KIND_X: begin
            qx_in = pv; qy_in = c0; qz_in = c1; qw_in = c2;
         end
         KIND_Y: begin
            qx_in = c0; qy_in = pv; qz_in = c1; qw_in = c2;
         end
         KIND_Z: begin
            qx_in = c0; qy_in = c1; qz_in = pv; qw_in = c2;
         end
         default: begin
            qx_in = '0; qy_in = '0; qz_in = '0; qw_in = '0;
         end
      endcase
      if (bad_in) begin
         qx_in = '0; qy_in = '0; qz_in = '0; qw_in = '0;
      end
   end

   // output register
   logic                   out_vld_ff;
   logic signed [IN_W-1:0] qx_ff, qy_ff, qz_ff, qw_ff;
   kind_type               kind_ff;
   logic                   bad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= vld_ff[SIDE_LAT-1];
      end
      if (en) begin
         qx_ff   <= qx_in;
         qy_ff   <= qy_in;
         qz_ff   <= qz_in;
         qw_ff   <= qw_in;
         kind_ff <= side_end.kind;
         bad_ff  <= bad_in;
      end
   end

   assign rsp.valid      = out_vld_ff;
   assign rsp.qx         = qx_ff;
   assign rsp.qy         = qy_ff;
   assign rsp.qz         = qz_ff;
   assign rsp.qw         = qw_ff;
   assign rsp.pivot_kind = kind_ff;
   assign rsp.bad_input  = bad_ff;
endmodule
`default_nettype wire

>>> hdl/mq_isqrt.sv
// Pipelined integer square root, SQ_PER result bits per stage.
`default_nettype none
module mq_isqrt (
   input  wire logic                          clock,
   input  wire logic                          en,
   input  wire logic [mq_pkg::SQ_IN_W-1:0]    rad_v,
   output      logic [mq_pkg::P_W-1:0]        p_out
);
   import mq_pkg::*;

   logic [SQ_IN_W-1:0] v_ff [SQ_STAGES];
   logic [SQ_IN_W-1:0] r_ff [SQ_STAGES];
   logic [SQ_IN_W-1:0] v_in [SQ_STAGES];
   logic [SQ_IN_W-1:0] r_in [SQ_STAGES];

   always_comb begin
      logic [SQ_IN_W-1:0] vv, rr, bitv, trial;
      for (int s = 0; s < SQ_STAGES; s++) begin
         if (s == 0) begin
            vv = rad_v;
            rr = '0;
         end else begin
            vv = v_ff[s-1];
            rr = r_ff[s-1];
         end
         for (int j = 0; j < SQ_PER; j++) begin
            if (s * SQ_PER + j < SQ_ITERS) begin
               bitv  = SQ_IN_W'(1) << (SQ_IN_W - 2 - 2 * (s * SQ_PER + j));
               trial = rr + bitv;
               if (vv >= trial) begin
                  vv = vv - trial;
                  rr = (rr >> 1) + bitv;
               end else begin
                  rr = rr >> 1;
               end
            end
         end
         v_in[s] = vv;
         r_in[s] = rr;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < SQ_STAGES; s++) begin
            v_ff[s] <= v_in[s];
            r_ff[s] <= r_in[s];
         end
      end
   end

   assign p_out = r_ff[SQ_STAGES-1][P_W-1:0];
endmodule
`default_nettype wire

>>> hdl/mq_div.sv
// Pipelined scaled divide: |d| * 2^FRAC_BITS / (4p), rounded, with overflow flag.
`default_nettype none
module mq_div (
   input  wire logic                            clock,
   input  wire logic                            en,
   input  wire logic signed [mq_pkg::D_W-1:0]   d,
   input  wire logic        [mq_pkg::P_W-1:0]   p,
   output      logic        [mq_pkg::Q_W-1:0]   q_out,
   output      logic                            neg_out,
   output      logic                            ovf_out
);
   import mq_pkg::*;

   logic [REM_W-1:0] rem_ff [DIV_LAT];
   logic [REM_W-1:0] rem_in [DIV_LAT];
   logic [DEN_W-1:0] den_ff [DIV_LAT];
   logic [DEN_W-1:0] den_in [DIV_LAT];
   logic [Q_W-1:0]   q_ff   [DIV_LAT];
   logic [Q_W-1:0]   q_in   [DIV_LAT];
   logic             neg_ff [DIV_LAT];
   logic             neg_in [DIV_LAT];
   logic             ovf_ff [DIV_LAT];
   logic             ovf_in [DIV_LAT];

   always_comb begin
      logic [D_W-1:0]   mag;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
      logic [REM_W-1:0] rr, sub;
      logic [Q_W-1:0]   qq;
      int               k;
      // setup stage: magnitude, rounded numerator, overflow test
      mag       = d[D_W-1] ? D_W'(-d) : D_W'(d);
      den       = {p, 2'b00};
      num       = (NUM_W'(mag) << FRAC_BITS) + NUM_W'({p, 1'b0});
      rem_in[0] = REM_W'(num);
      den_in[0] = den;
      q_in[0]   = '0;
      neg_in[0] = d[D_W-1];
      ovf_in[0] = REM_W'(num) >= (REM_W'(den) << Q_W);
      for (int s = 1; s < DIV_LAT; s++) begin
         rr = rem_ff[s-1];
         qq = q_ff[s-1];
         for (int j = 0; j < DV_PER; j++) begin
            k = Q_W - 1 - ((s - 1) * DV_PER + j);
            if (k >= 0) begin
               sub = REM_W'(den_ff[s-1]) << k;
               if (rr >= sub) begin
                  rr = rr - sub;
                  qq[k] = 1'b1;
               end
            end
         end
         rem_in[s] = rr;
         den_in[s] = den_ff[s-1];
         q_in[s]   = qq;
         neg_in[s] = neg_ff[s-1];
         ovf_in[s] = ovf_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < DIV_LAT; s++) begin
            rem_ff[s] <= rem_in[s];
            den_ff[s] <= den_in[s];
            q_ff[s]   <= q_in[s];
            neg_ff[s] <= neg_in[s];
            ovf_ff[s] <= ovf_in[s];
         end
      end
   end

   assign q_out   = q_ff[DIV_LAT-1];
   assign neg_out = neg_ff[DIV_LAT-1];
   assign ovf_out = ovf_ff[DIV_LAT-1];
endmodule
`default_nettype wire
